FILE: design/bcba_pkg.sv
`default_nettype none

package bcba_pkg;

  localparam int MAP_BLOCKS_DEF  = 65536;
  localparam int WORD_BITS_DEF   = 32;
  localparam int BLOCK_SHIFT_DEF = 13;

  localparam int CMD_W   = 2;
  localparam int LEN_W   = 17;
  localparam int WIDX_W  = 11;
  localparam int DATA_W  = 32;
  localparam int FIRST_W = 16;
  localparam int ADDR_W  = 32;

  localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h0110_0000;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  run_length;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] word_data;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [FIRST_W-1:0] first_block;
    logic [ADDR_W-1:0]  block_address;
    logic [DATA_W-1:0]  read_word;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/bcba_map_ram.sv
`default_nettype none

module bcba_map_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32,
  parameter int AW    = 11
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/bitmap_contiguous_block_allocator.sv
`default_nettype none

// channel   ports                        handshake
// request   start, busy, in_req          taken when start && !busy
// result    out_valid, out_rsp           one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_data  written when cfg_valid && cfg_ready
//
// Write and unused commands: result the next cycle, next request at once.
// Read: one map RAM read, result via ST_READ and the output register. Zero or oversized
// run length: result in the cycle after the request. Allocate: per map word one RAM
// read and an 8-bit scan per chunk, then a read and a write per marked word.
// After reset a clearing pass writes MAP_WORDS words with busy high.
// The result side cannot stall; cfg_ready is always high.

module bitmap_contiguous_block_allocator #(
  parameter int MAP_BLOCKS  = bcba_pkg::MAP_BLOCKS_DEF,
  parameter int WORD_BITS   = bcba_pkg::WORD_BITS_DEF,
  parameter int BLOCK_SHIFT = bcba_pkg::BLOCK_SHIFT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bcba_pkg::req_t                in_req,
  output logic                               out_valid,
  output bcba_pkg::rsp_t                     out_rsp,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bcba_pkg::ADDR_W-1:0]   cfg_data
);

  localparam int MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int NCHUNK    = (WORD_BITS + 7) / 8;
  localparam int CW        = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int OW        = CW + 3;
  localparam int BKW       = $clog2(MAP_BLOCKS);
  localparam int CNTW      = $clog2(MAP_BLOCKS + 1);
  localparam int LW        = (CNTW > bcba_pkg::LEN_W) ? CNTW : bcba_pkg::LEN_W;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_SCAN_RD = 3'd3;
  localparam logic [2:0] ST_SCAN    = 3'd4;
  localparam logic [2:0] ST_MARK_RD = 3'd5;
  localparam logic [2:0] ST_MARK_WR = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [AW-1:0]                   w_r, w_nxt;
  logic [CW-1:0]                   chunk_r, chunk_nxt;
  logic [CNTW-1:0]                 cnt_r, cnt_nxt;
  logic [bcba_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [BKW-1:0]                  sblk_r, sblk_nxt;
  logic [AW-1:0]                   sword_r, sword_nxt;
  logic [OW-1:0]                   soff_r, soff_nxt;
  logic [AW-1:0]                   eword_r, eword_nxt;
  logic [OW-1:0]                   eoff_r, eoff_nxt;
  logic                            rd_ok_r, rd_ok_nxt;
  logic                            out_valid_r, out_valid_nxt;
  bcba_pkg::rsp_t                  out_rsp_r, out_rsp_nxt;
  logic [bcba_pkg::ADDR_W-1:0]     region_base_r;

  logic                            ram_wr_en, ram_rd_en;
  logic [AW-1:0]                   ram_wr_addr, ram_rd_addr;
  logic [WORD_BITS-1:0]            ram_wr_data, ram_rd_data;

  logic                            accept;
  logic                            widx_ok;

  logic [NCHUNK*8-1:0]             word_ext;
  logic [7:0]                      cbits;
  logic [BKW:0]                    blk_base;
  logic [BKW:0]                    blk;
  logic [OW-1:0]                   off;
  logic [CNTW-1:0]                 sc_cnt;
  logic [BKW-1:0]                  sc_sblk;
  logic [AW-1:0]                   sc_sword;
  logic [OW-1:0]                   sc_soff;
  logic [OW-1:0]                   sc_eoff;
  logic                            sc_hit;

  logic [OW-1:0]                   mk_lo, mk_hi;
  logic [WORD_BITS-1:0]            mk_mask;

  bcba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign cfg_ready = 1'b1;
  assign widx_ok   = (32'(in_req.word_index) < 32'(MAP_WORDS));

  // scan eight bits of the current word, carrying the free run across chunks
  always_comb begin
    word_ext = (NCHUNK*8)'(ram_rd_data);
    cbits    = 8'(word_ext >> {chunk_r, 3'b000});
    blk_base = (BKW+1)'(32'(w_r) * 32'(WORD_BITS));
    sc_cnt   = cnt_r;
    sc_sblk  = sblk_r;
    sc_sword = sword_r;
    sc_soff  = soff_r;
    sc_eoff  = eoff_r;
    sc_hit   = 1'b0;
    off      = '0;
    blk      = '0;
    for (int i = 0; i < 8; i++) begin
      off = {chunk_r, 3'(i)};
      blk = blk_base + (BKW+1)'(off);
      if (!sc_hit && (32'(off) < 32'(WORD_BITS)) && (blk < (BKW+1)'(MAP_BLOCKS))) begin
        if (cbits[i]) begin
          sc_cnt = '0;
        end else begin
          if (sc_cnt == '0) begin
            sc_sblk  = blk[BKW-1:0];
            sc_sword = w_r;
            sc_soff  = off;
          end
          sc_cnt = sc_cnt + CNTW'(1);
          if (LW'(sc_cnt) == LW'(len_r)) begin
            sc_hit  = 1'b1;
            sc_eoff = off;
          end
        end
      end
    end
  end

  always_comb begin
    mk_lo = (w_r == sword_r) ? soff_r : '0;
    mk_hi = (w_r == eword_r) ? eoff_r : OW'(WORD_BITS - 1);
    for (int k = 0; k < WORD_BITS; k++) begin
      mk_mask[k] = (32'(k) >= 32'(mk_lo)) && (32'(k) <= 32'(mk_hi));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    sblk_nxt      = sblk_r;
    sword_nxt     = sword_r;
    soff_nxt      = soff_r;
    eword_nxt     = eword_r;
    eoff_nxt      = eoff_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = w_r;
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = w_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
        if (w_r == AW'(MAP_WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          w_nxt = w_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          out_rsp_nxt = '0;
          unique case (in_req.command)
            bcba_pkg::CMD_ALLOC: begin
              if ((in_req.run_length == '0) ||
                  (32'(in_req.run_length) > 32'(MAP_BLOCKS))) begin
                out_valid_nxt = 1'b1;
              end else begin
                len_nxt   = in_req.run_length;
                cnt_nxt   = '0;
                w_nxt     = '0;
                state_nxt = ST_SCAN_RD;
              end
            end
            bcba_pkg::CMD_WRITE: begin
              ram_wr_en         = widx_ok;
              ram_wr_addr       = AW'(in_req.word_index);
              ram_wr_data       = WORD_BITS'(in_req.word_data);
              out_valid_nxt     = 1'b1;
              out_rsp_nxt.found = 1'b1;
            end
            bcba_pkg::CMD_READ: begin
              ram_rd_en   = widx_ok;
              ram_rd_addr = AW'(in_req.word_index);
              rd_ok_nxt   = widx_ok;
              state_nxt   = ST_READ;
            end
            bcba_pkg::CMD_NONE: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.found     = 1'b1;
        out_rsp_nxt.read_word = rd_ok_r ? bcba_pkg::DATA_W'(ram_rd_data) : '0;
        state_nxt             = ST_IDLE;
      end

      ST_SCAN_RD: begin
        ram_rd_en = 1'b1;
        chunk_nxt = '0;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        cnt_nxt   = sc_cnt;
        sblk_nxt  = sc_sblk;
        sword_nxt = sc_sword;
        soff_nxt  = sc_soff;
        if (sc_hit) begin
          eword_nxt = w_r;
          eoff_nxt  = sc_eoff;
          w_nxt     = sc_sword;
          state_nxt = ST_MARK_RD;
        end else if (chunk_r == CW'(NCHUNK - 1)) begin
          if (w_r == AW'(MAP_WORDS - 1)) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
            state_nxt     = ST_IDLE;
          end else begin
            w_nxt     = w_r + AW'(1);
            state_nxt = ST_SCAN_RD;
          end
        end else begin
          chunk_nxt = chunk_r + CW'(1);
        end
      end

      ST_MARK_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data | mk_mask;
        if (w_r == eword_r) begin
          out_valid_nxt             = 1'b1;
          out_rsp_nxt.found         = 1'b1;
          out_rsp_nxt.first_block   = bcba_pkg::FIRST_W'(sblk_r);
          out_rsp_nxt.block_address = region_base_r +
                                      (bcba_pkg::ADDR_W'(sblk_r) << BLOCK_SHIFT);
          out_rsp_nxt.read_word     = '0;
          state_nxt                 = ST_IDLE;
        end else begin
          w_nxt     = w_r + AW'(1);
          state_nxt = ST_MARK_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      w_r           <= '0;
      out_valid_r   <= 1'b0;
      region_base_r <= bcba_pkg::REGION_BASE_RST;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        region_base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chunk_r   <= chunk_nxt;
    cnt_r     <= cnt_nxt;
    len_r     <= len_nxt;
    sblk_r    <= sblk_nxt;
    sword_r   <= sword_nxt;
    soff_r    <= soff_nxt;
    eword_r   <= eword_nxt;
    eoff_r    <= eoff_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

`default_nettype wire

FILE: design/bcba_checker.sv
`default_nettype none

module bcba_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire bcba_pkg::req_t              in_req,
  input wire logic                        out_valid,
  input wire bcba_pkg::rsp_t              out_rsp
);

  logic accept;
  assign accept = start && !busy;

  // clearing pass holds off requests right after reset
  a_clear_busy: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req.command == bcba_pkg::CMD_WRITE) |=> out_valid && out_rsp.found)
    else $error("write request did not complete next cycle");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req.command == bcba_pkg::CMD_READ) |=> busy ##1 out_valid && out_rsp.found)
    else $error("read request did not complete in two cycles");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req.command == bcba_pkg::CMD_ALLOC) && (in_req.run_length == '0)
    |=> out_valid && !out_rsp.found)
    else $error("zero length allocate not rejected next cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.found |->
      (out_rsp.first_block == '0) && (out_rsp.block_address == '0) &&
      (out_rsp.read_word == '0))
    else $error("failed result carries nonzero fields");

endmodule

bind bitmap_contiguous_block_allocator bcba_checker u_bcba_checker (.*);

`default_nettype wire
